### sv/hrf_pkg.sv
// Shared types, codes and defaults for the head rule finder.
`default_nettype none
package hrf_pkg;

   // Default sizes of the rule tables and the child buffer
   localparam int LABEL_COUNT_DEF  = 256;
   localparam int MAX_CHILDREN_DEF = 16;
   localparam int MAX_RULES_DEF    = 4;
   localparam int MAX_PRIORITY_DEF = 8;

   // Fixed field widths
   localparam int OPCODE_W = 3;
   localparam int LABEL_W  = 8;
   localparam int SLOT_W   = 2;
   localparam int COUNT_W  = 4;
   localparam int PSLOT_W  = 3;
   localparam int HEAD_W   = 4;
   localparam int HOW_W    = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_RULE_COUNT = 3'd0,
      OP_RULE_HDR   = 3'd1,
      OP_PRIO_ENTRY = 3'd2,
      OP_PUNCT_MARK = 3'd3,
      OP_CHILD      = 3'd4
   } op_type;

   typedef enum logic [HOW_W-1:0] {
      HOW_PRIO     = 2'd0,
      HOW_NONPUNCT = 2'd1,
      HOW_EDGE     = 2'd2,
      HOW_NONE     = 2'd3
   } how_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COUNT,
      ST_RULE,
      ST_PRIO,
      ST_SCAN,
      ST_FB_CHILD,
      ST_FB_PUNCT
   } state_type;

endpackage
`default_nettype wire

### sv/hrf_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module hrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port; a read of the entry being written gives old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= storage_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### sv/head_rule_finder.sv
// Head rule finder top level: rule tables, child buffer and search sequencer.
//
//  channel   ports                      transfer
//  request   start, busy, req_*         start high and busy low at a clock edge
//  response  rsp_valid, rsp_*           rsp_valid high for one cycle, always taken
//
// Table items and non-last children are taken while idle and leave busy low.
// A last child starts a search: the count lookup, each rule header, each priority
// label followed by the children compared against it, and the non-punctuation
// fallback with a child read and a punctuation lookup per child, then the response.
// After reset a clearing pass over the rule-count and punctuation memories
// writes zeros to all min(LABEL_COUNT,256) entries with busy high.
// The response cannot be stalled; the block is idle again in the cycle it is shown.
`default_nettype none
module head_rule_finder #(
   parameter int LABEL_COUNT  = hrf_pkg::LABEL_COUNT_DEF,
   parameter int MAX_CHILDREN = hrf_pkg::MAX_CHILDREN_DEF,
   parameter int MAX_RULES    = hrf_pkg::MAX_RULES_DEF,
   parameter int MAX_PRIORITY = hrf_pkg::MAX_PRIORITY_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [hrf_pkg::OPCODE_W-1:0] req_opcode,
   input  wire logic [hrf_pkg::LABEL_W-1:0]  req_label,
   input  wire logic [hrf_pkg::SLOT_W-1:0]   req_rule_slot,
   input  wire logic                         req_direction,
   input  wire logic [hrf_pkg::COUNT_W-1:0]  req_count,
   input  wire logic [hrf_pkg::PSLOT_W-1:0]  req_priority_slot,
   input  wire logic [hrf_pkg::LABEL_W-1:0]  req_symbol,
   input  wire logic                         req_flag,
   input  wire logic                         req_last,
   output logic                              rsp_valid,
   output logic      [hrf_pkg::HEAD_W-1:0]   rsp_head_index,
   output logic      [hrf_pkg::HOW_W-1:0]    rsp_how_found,
   output logic                              rsp_overflow
);
   import hrf_pkg::*;

   // Only labels reachable through the 8-bit field get storage
   localparam int LBL_DEPTH = (LABEL_COUNT < 256) ? LABEL_COUNT : 256;
   localparam int LBL_AW    = $clog2(LBL_DEPTH);
   localparam int RI_DEPTH  = LBL_DEPTH * MAX_RULES;
   localparam int RI_AW     = $clog2(RI_DEPTH);
   localparam int PA_DEPTH  = RI_DEPTH * MAX_PRIORITY;
   localparam int PA_AW     = $clog2(PA_DEPTH);
   localparam int CNT_W     = $clog2(MAX_RULES + 1);
   localparam int LEN_W     = $clog2(MAX_PRIORITY + 1);
   localparam int R_W       = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int P_W       = (MAX_PRIORITY > 1) ? $clog2(MAX_PRIORITY) : 1;
   localparam int CA_W      = $clog2(MAX_CHILDREN);
   localparam int N_W       = $clog2(MAX_CHILDREN + 1);

   state_type        state_ff, state_in;
   logic [LBL_AW-1:0] clr_ff, clr_in;
   logic [LBL_AW-1:0] node_ff, node_in;
   logic              node_ok_ff, node_ok_in;
   logic [CNT_W-1:0]  nr_ff, nr_in;
   logic [R_W-1:0]    r_ff, r_in;
   logic              dir_ff, dir_in;
   logic              dir0_ff, dir0_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [P_W-1:0]    p_ff, p_in;
   logic [LABEL_W-1:0] want_ff, want_in;
   logic [CA_W-1:0]   k_ff, k_in;
   logic [N_W-1:0]    nchild_ff, nchild_in;
   logic              ovf_ff, ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [HEAD_W-1:0] rsp_head_ff, rsp_head_in;
   logic [HOW_W-1:0]  rsp_how_ff, rsp_how_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   // memory ports
   logic              cnt_we, pun_we, rule_we, prio_we, child_we;
   logic [LBL_AW-1:0] cnt_wa, pun_wa, cnt_ra, pun_ra;
   logic [CNT_W-1:0]  cnt_wd, cnt_rd;
   logic              pun_wd, pun_rd;
   logic [RI_AW-1:0]  rule_wa, rule_ra;
   logic [LEN_W:0]    rule_wd, rule_rd;
   logic [PA_AW-1:0]  prio_wa, prio_ra;
   logic [LABEL_W-1:0] prio_wd, prio_rd;
   logic [CA_W-1:0]   child_wa, child_ra;
   logic [LABEL_W-1:0] child_wd, child_rd;

   // decoded request and search conditions
   logic      accept;
   op_type    op;
   logic      lbl_ok, slot_ok, pslot_ok, child_room;
   logic      rule_dir;
   logic [LEN_W-1:0] rule_len;
   logic      dir0_now;
   logic      r_more, p_more, k_more, match, child_lbl_ok;
   logic [CA_W-1:0] pos_k, pos0_k, pos_k1, pos0_k1, pos_first, pos0_first;
   logic [RI_AW-1:0] ri_cur, ri_next;
   logic [PA_AW-1:0] pa_first, pa_next;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign op     = op_type'(req_opcode);

   assign lbl_ok     = int'(req_label) < LABEL_COUNT;
   assign slot_ok    = int'(req_rule_slot) < MAX_RULES;
   assign pslot_ok   = int'(req_priority_slot) < MAX_PRIORITY;
   assign child_room = int'(nchild_ff) < MAX_CHILDREN;

   assign rule_dir  = rule_rd[LEN_W];
   assign rule_len  = rule_rd[LEN_W-1:0];
   assign dir0_now  = (r_ff == '0) ? rule_dir : dir0_ff;
   assign r_more    = int'(r_ff) + 1 < int'(nr_ff);
   assign p_more    = int'(p_ff) + 1 < int'(len_ff);
   assign k_more    = int'(k_ff) + 1 < int'(nchild_ff);
   assign match     = (child_rd == want_ff);
   assign child_lbl_ok = int'(child_rd) < LABEL_COUNT;

   // child positions for the current and next scan step
   assign pos_k      = dir_ff  ? CA_W'(int'(nchild_ff) - 1 - int'(k_ff)) : k_ff;
   assign pos0_k     = dir0_ff ? CA_W'(int'(nchild_ff) - 1 - int'(k_ff)) : k_ff;
   assign pos_k1     = dir_ff  ? CA_W'(int'(nchild_ff) - 2 - int'(k_ff))
                               : CA_W'(int'(k_ff) + 1);
   assign pos0_k1    = dir0_ff ? CA_W'(int'(nchild_ff) - 2 - int'(k_ff))
                               : CA_W'(int'(k_ff) + 1);
   assign pos_first  = dir_ff  ? CA_W'(int'(nchild_ff) - 1) : '0;
   assign pos0_first = dir0_now ? CA_W'(int'(nchild_ff) - 1) : '0;

   // table addresses
   assign ri_cur   = RI_AW'(int'(node_ff) * MAX_RULES + int'(r_ff));
   assign ri_next  = RI_AW'(int'(node_ff) * MAX_RULES + int'(r_ff) + 1);
   assign pa_first = PA_AW'(int'(ri_cur) * MAX_PRIORITY);
   assign pa_next  = PA_AW'(int'(ri_cur) * MAX_PRIORITY + int'(p_ff) + 1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (int'(clr_ff) == LBL_DEPTH - 1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && op == OP_CHILD && req_last) state_in = ST_COUNT;
         end
         ST_COUNT: begin
            if (!node_ok_ff || cnt_rd == '0 || nchild_ff == '0) state_in = ST_IDLE;
            else state_in = ST_RULE;
         end
         ST_RULE: begin
            if (rule_len != '0) state_in = ST_PRIO;
            else if (r_more) state_in = ST_RULE;
            else state_in = ST_FB_CHILD;
         end
         ST_PRIO: state_in = ST_SCAN;
         ST_SCAN: begin
            if (match) state_in = ST_IDLE;
            else if (k_more) state_in = ST_SCAN;
            else if (p_more) state_in = ST_PRIO;
            else if (r_more) state_in = ST_RULE;
            else state_in = ST_FB_CHILD;
         end
         ST_FB_CHILD: begin
            if (!child_lbl_ok) state_in = ST_IDLE;
            else state_in = ST_FB_PUNCT;
         end
         ST_FB_PUNCT: begin
            if (!pun_rd || !k_more) state_in = ST_IDLE;
            else state_in = ST_FB_CHILD;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath registers, responses and memory accesses
   always_comb begin
      clr_in       = clr_ff;
      node_in      = node_ff;
      node_ok_in   = node_ok_ff;
      nr_in        = nr_ff;
      r_in         = r_ff;
      dir_in       = dir_ff;
      dir0_in      = dir0_ff;
      len_in       = len_ff;
      p_in         = p_ff;
      want_in      = want_ff;
      k_in         = k_ff;
      nchild_in    = nchild_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = 1'b0;
      rsp_head_in  = rsp_head_ff;
      rsp_how_in   = rsp_how_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      cnt_we   = 1'b0;
      cnt_wa   = req_label[LBL_AW-1:0];
      cnt_wd   = (int'(req_count) > MAX_RULES) ? CNT_W'(MAX_RULES) : CNT_W'(req_count);
      cnt_ra   = req_label[LBL_AW-1:0];
      pun_we   = 1'b0;
      pun_wa   = req_label[LBL_AW-1:0];
      pun_wd   = req_flag;
      pun_ra   = child_rd[LBL_AW-1:0];
      rule_we  = 1'b0;
      rule_wa  = RI_AW'(int'(req_label[LBL_AW-1:0]) * MAX_RULES + int'(req_rule_slot));
      rule_wd  = {req_direction, (int'(req_count) > MAX_PRIORITY) ?
                  LEN_W'(MAX_PRIORITY) : LEN_W'(req_count)};
      rule_ra  = ri_cur;
      prio_we  = 1'b0;
      prio_wa  = PA_AW'((int'(req_label[LBL_AW-1:0]) * MAX_RULES + int'(req_rule_slot))
                 * MAX_PRIORITY + int'(req_priority_slot));
      prio_wd  = req_symbol;
      prio_ra  = pa_first;
      child_we = 1'b0;
      child_wa = CA_W'(nchild_ff);
      child_wd = req_symbol;
      child_ra = pos_first;

      case (state_ff)
         // sweep zeros into rule counts and punctuation marks
         ST_CLEAR: begin
            cnt_we = 1'b1;
            cnt_wa = clr_ff;
            cnt_wd = '0;
            pun_we = 1'b1;
            pun_wa = clr_ff;
            pun_wd = 1'b0;
            clr_in = LBL_AW'(int'(clr_ff) + 1);
         end
         // table writes and child loading
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_RULE_COUNT: cnt_we  = lbl_ok;
                  OP_RULE_HDR:   rule_we = lbl_ok && slot_ok;
                  OP_PRIO_ENTRY: prio_we = lbl_ok && slot_ok && pslot_ok;
                  OP_PUNCT_MARK: pun_we  = lbl_ok;
                  OP_CHILD: begin
                     if (child_room) begin
                        child_we  = 1'b1;
                        nchild_in = N_W'(int'(nchild_ff) + 1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                     node_in    = req_label[LBL_AW-1:0];
                     node_ok_in = lbl_ok;
                  end
                  default: ;
               endcase
            end
         end
         // rule count arrived
         ST_COUNT: begin
            nr_in   = cnt_rd;
            r_in    = '0;
            rule_ra = RI_AW'(int'(node_ff) * MAX_RULES);
            if (!node_ok_ff || cnt_rd == '0 || nchild_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_head_in  = '0;
               rsp_how_in   = HOW_NONE;
               rsp_ovf_in   = ovf_ff;
               nchild_in    = '0;
               ovf_in       = 1'b0;
            end
         end
         // rule header arrived
         ST_RULE: begin
            dir_in  = rule_dir;
            len_in  = rule_len;
            dir0_in = dir0_now;
            p_in    = '0;
            k_in    = '0;
            prio_ra = pa_first;
            rule_ra = ri_next;
            child_ra = pos0_first;
            if (rule_len == '0 && r_more) r_in = R_W'(int'(r_ff) + 1);
         end
         // priority label arrived, fetch first child
         ST_PRIO: begin
            want_in  = prio_rd;
            k_in     = '0;
            child_ra = pos_first;
         end
         // compare one child per cycle
         ST_SCAN: begin
            if (match) begin
               rsp_valid_in = 1'b1;
               rsp_head_in  = HEAD_W'(pos_k);
               rsp_how_in   = HOW_PRIO;
               rsp_ovf_in   = ovf_ff;
               nchild_in    = '0;
               ovf_in       = 1'b0;
            end else if (k_more) begin
               k_in     = CA_W'(int'(k_ff) + 1);
               child_ra = pos_k1;
            end else if (p_more) begin
               p_in    = P_W'(int'(p_ff) + 1);
               prio_ra = pa_next;
            end else if (r_more) begin
               r_in    = R_W'(int'(r_ff) + 1);
               rule_ra = ri_next;
            end else begin
               k_in     = '0;
               child_ra = dir0_ff ? CA_W'(int'(nchild_ff) - 1) : '0;
            end
         end
         // fallback: child label arrived, look up its punctuation mark
         ST_FB_CHILD: begin
            pun_ra = child_rd[LBL_AW-1:0];
            if (!child_lbl_ok) begin
               rsp_valid_in = 1'b1;
               rsp_head_in  = HEAD_W'(pos0_k);
               rsp_how_in   = HOW_NONPUNCT;
               rsp_ovf_in   = ovf_ff;
               nchild_in    = '0;
               ovf_in       = 1'b0;
            end
         end
         ST_FB_PUNCT: begin
            if (!pun_rd) begin
               rsp_valid_in = 1'b1;
               rsp_head_in  = HEAD_W'(pos0_k);
               rsp_how_in   = HOW_NONPUNCT;
               rsp_ovf_in   = ovf_ff;
               nchild_in    = '0;
               ovf_in       = 1'b0;
            end else if (k_more) begin
               k_in     = CA_W'(int'(k_ff) + 1);
               child_ra = pos0_k1;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_head_in  = dir0_ff ? HEAD_W'(int'(nchild_ff) - 1) : '0;
               rsp_how_in   = HOW_EDGE;
               rsp_ovf_in   = ovf_ff;
               nchild_in    = '0;
               ovf_in       = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         nchild_ff    <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         nchild_ff    <= nchild_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      node_ok_ff  <= node_ok_in;
      nr_ff       <= nr_in;
      r_ff        <= r_in;
      dir_ff      <= dir_in;
      dir0_ff     <= dir0_in;
      len_ff      <= len_in;
      p_ff        <= p_in;
      want_ff     <= want_in;
      k_ff        <= k_in;
      rsp_head_ff <= rsp_head_in;
      rsp_how_ff  <= rsp_how_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_head_index = rsp_head_ff;
   assign rsp_how_found  = rsp_how_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   // memories
   hrf_ram #(.WIDTH(CNT_W), .DEPTH(LBL_DEPTH)) u_count_ram (
      .clock, .wr_en(cnt_we), .wr_addr(cnt_wa), .wr_data(cnt_wd),
      .rd_addr(cnt_ra), .rd_data(cnt_rd));

   hrf_ram #(.WIDTH(1), .DEPTH(LBL_DEPTH)) u_punct_ram (
      .clock, .wr_en(pun_we), .wr_addr(pun_wa), .wr_data(pun_wd),
      .rd_addr(pun_ra), .rd_data(pun_rd));

   hrf_ram #(.WIDTH(LEN_W + 1), .DEPTH(RI_DEPTH)) u_rule_ram (
      .clock, .wr_en(rule_we), .wr_addr(rule_wa), .wr_data(rule_wd),
      .rd_addr(rule_ra), .rd_data(rule_rd));

   hrf_ram #(.WIDTH(LABEL_W), .DEPTH(PA_DEPTH)) u_prio_ram (
      .clock, .wr_en(prio_we), .wr_addr(prio_wa), .wr_data(prio_wd),
      .rd_addr(prio_ra), .rd_data(prio_rd));

   hrf_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_CHILDREN)) u_child_ram (
      .clock, .wr_en(child_we), .wr_addr(child_wa), .wr_data(child_wd),
      .rd_addr(child_ra), .rd_data(child_rd));

   // checks
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe held for two cycles");

   a_rsp_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (nchild_ff == '0 && !ovf_ff && state_ff == ST_IDLE))
      else $error("node state not cleared with response");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_FB_CHILD || state_ff == ST_FB_PUNCT)
      |-> (int'(k_ff) < int'(nchild_ff)))
      else $error("scan step beyond child count");

   a_child_cap: assert property (@(posedge clock) disable iff (reset)
      int'(nchild_ff) <= MAX_CHILDREN)
      else $error("child count beyond capacity");

endmodule
`default_nettype wire

### tb/sv/hrf_checker.sv
// Head rule finder checker: watches both channels, predicts each head and compares.
module hrf_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic                         busy,
   input  wire logic [hrf_pkg::OPCODE_W-1:0] req_opcode,
   input  wire logic [hrf_pkg::LABEL_W-1:0]  req_label,
   input  wire logic [hrf_pkg::SLOT_W-1:0]   req_rule_slot,
   input  wire logic                         req_direction,
   input  wire logic [hrf_pkg::COUNT_W-1:0]  req_count,
   input  wire logic [hrf_pkg::PSLOT_W-1:0]  req_priority_slot,
   input  wire logic [hrf_pkg::LABEL_W-1:0]  req_symbol,
   input  wire logic                         req_flag,
   input  wire logic                         req_last,
   input  wire logic                         rsp_valid,
   input  wire logic [hrf_pkg::HEAD_W-1:0]   rsp_head_index,
   input  wire logic [hrf_pkg::HOW_W-1:0]    rsp_how_found,
   input  wire logic                         rsp_overflow,
   output int                                fail_count,
   output int                                heads_pending,
   output int                                heads_checked,
   output int                                overflow_nodes
);
   import hrf_pkg::*;

   typedef struct {
      logic [HEAD_W-1:0] head;
      how_type           how;
      logic              ovf;
   } head_pick_type;

   // Shadow copy of the rule tables and the child buffer
   logic [2:0]         rule_num   [256];
   logic               rule_dir   [256][MAX_RULES_DEF];
   logic [3:0]         rule_len   [256][MAX_RULES_DEF];
   logic [LABEL_W-1:0] prio_label [256][MAX_RULES_DEF][MAX_PRIORITY_DEF];
   logic               punct_flag [256];
   logic [LABEL_W-1:0] kids       [MAX_CHILDREN_DEF];
   int                 kid_count;
   logic               kid_overflow;
   head_pick_type      heads_due[$];

   // Priority search, then non-punctuation fallback, then edge child; none without rules or children
   function automatic void pick_head(input logic [LABEL_W-1:0] node,
                                     output logic [HEAD_W-1:0] hd, output how_type hw);
      int n;
      int pos;
      logic d0;
      n = kid_count;
      if (rule_num[node] == 0 || n == 0) begin
         hd = '0; hw = HOW_NONE; return;
      end
      for (int r = 0; r < rule_num[node]; r++) begin
         for (int p = 0; p < rule_len[node][r]; p++) begin
            for (int k = 0; k < n; k++) begin
               pos = rule_dir[node][r] ? n - 1 - k : k;
               if (kids[pos] == prio_label[node][r][p]) begin
                  hd = pos[HEAD_W-1:0]; hw = HOW_PRIO; return;
               end
            end
         end
      end
      d0 = rule_dir[node][0];
      for (int k = 0; k < n; k++) begin
         pos = d0 ? n - 1 - k : k;
         if (!punct_flag[kids[pos]]) begin
            hd = pos[HEAD_W-1:0]; hw = HOW_NONPUNCT; return;
         end
      end
      hd = d0 ? HEAD_W'(n - 1) : '0;
      hw = HOW_EDGE;
   endfunction

   assign heads_pending = heads_due.size();

   always @(posedge clock) begin
      head_pick_type want;
      logic [HEAD_W-1:0] hd;
      how_type hw;
      if (reset) begin
         foreach (rule_num[i]) rule_num[i] = '0;
         foreach (punct_flag[i]) punct_flag[i] = 1'b0;
         kid_count = 0;
         kid_overflow = 1'b0;
         heads_due.delete();
         fail_count <= 0;
         heads_checked <= 0;
         overflow_nodes <= 0;
      end else begin
         // Result transfer: compare with the oldest expected head
         if (rsp_valid) begin
            heads_checked <= heads_checked + 1;
            if (heads_due.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("checker: unexpected result head=%0d how=%0d ovf=%0d",
                           rsp_head_index, rsp_how_found, rsp_overflow);
            end else begin
               want = heads_due.pop_front();
               if (want.head !== rsp_head_index || want.how !== rsp_how_found ||
                   want.ovf !== rsp_overflow) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("checker: mismatch exp head=%0d how=%0d ovf=%0d, got %0d %0d %0d",
                              want.head, want.how, want.ovf,
                              rsp_head_index, rsp_how_found, rsp_overflow);
               end
            end
         end
         // Request transfer: update the shadow state
         if (start && !busy) begin
            case (req_opcode)
               OP_RULE_COUNT:
                  rule_num[req_label] = req_count > MAX_RULES_DEF ? 3'(MAX_RULES_DEF)
                                                                  : req_count[2:0];
               OP_RULE_HDR: begin
                  rule_dir[req_label][req_rule_slot] = req_direction;
                  rule_len[req_label][req_rule_slot] =
                     req_count > MAX_PRIORITY_DEF ? 4'(MAX_PRIORITY_DEF) : req_count;
               end
               OP_PRIO_ENTRY:
                  prio_label[req_label][req_rule_slot][req_priority_slot] = req_symbol;
               OP_PUNCT_MARK:
                  punct_flag[req_label] = req_flag;
               OP_CHILD: begin
                  if (kid_count < MAX_CHILDREN_DEF) begin
                     kids[kid_count] = req_symbol;
                     kid_count++;
                  end else
                     kid_overflow = 1'b1;
                  if (req_last) begin
                     pick_head(req_label, hd, hw);
                     want.head = hd; want.how = hw; want.ovf = kid_overflow;
                     if (kid_overflow) overflow_nodes <= overflow_nodes + 1;
                     heads_due = {heads_due, want};
                     kid_count = 0;
                     kid_overflow = 1'b0;
                  end
               end
               default: ;
            endcase
         end
      end
   end

endmodule

### tb/sv/tb_head_rule_finder.sv
// Testbench top for the head rule finder: stimulus, watchdog and verdict.
module tb_head_rule_finder;
   import hrf_pkg::*;

   localparam int IDLE_LIMIT = 5000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OPCODE_W-1:0] req_opcode = '0;
   logic [LABEL_W-1:0]  req_label = '0;
   logic [SLOT_W-1:0]   req_rule_slot = '0;
   logic                req_direction = 1'b0;
   logic [COUNT_W-1:0]  req_count = '0;
   logic [PSLOT_W-1:0]  req_priority_slot = '0;
   logic [LABEL_W-1:0]  req_symbol = '0;
   logic                req_flag = 1'b0;
   logic                req_last = 1'b0;
   logic                rsp_valid;
   logic [HEAD_W-1:0]   rsp_head_index;
   logic [HOW_W-1:0]    rsp_how_found;
   logic                rsp_overflow;
   int                  fail_count, heads_pending, heads_checked, overflow_nodes;

   // Which table entries have been written: the search never reads others
   bit hdr_written  [256][4];
   bit prio_written [256][4][8];
   int items_sent;
   int stall_cycles;
   bit quiet;
   bit bursty;

   head_rule_finder DUT (
      .clock, .reset, .start, .busy, .req_opcode, .req_label, .req_rule_slot,
      .req_direction, .req_count, .req_priority_slot, .req_symbol, .req_flag,
      .req_last, .rsp_valid, .rsp_head_index, .rsp_how_found, .rsp_overflow
   );

   hrf_checker u_checker (
      .clock, .reset, .start, .busy, .req_opcode, .req_label, .req_rule_slot,
      .req_direction, .req_count, .req_priority_slot, .req_symbol, .req_flag,
      .req_last, .rsp_valid, .rsp_head_index, .rsp_how_found, .rsp_overflow,
      .fail_count, .heads_pending, .heads_checked, .overflow_nodes
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // One request transfer, with an occasional idle burst ahead of it
   task automatic issue(input logic [OPCODE_W-1:0] op, input logic [7:0] lab,
                        input logic [1:0] rs, input logic dir, input logic [3:0] cnt,
                        input logic [2:0] ps, input logic [7:0] sym, input logic flg,
                        input logic lst);
      if (!quiet && bursty && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op; req_label <= lab; req_rule_slot <= rs; req_direction <= dir;
      req_count <= cnt; req_priority_slot <= ps; req_symbol <= sym; req_flag <= flg;
      req_last <= lst;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic write_prio(input logic [7:0] lab, input logic [1:0] rs,
                             input logic [2:0] ps, input logic [7:0] sym);
      issue(OP_PRIO_ENTRY, lab, rs, 1'($urandom), 4'($urandom), ps, sym,
            1'($urandom), 1'($urandom));
      prio_written[lab][rs][ps] = 1'b1;
   endtask

   // Rule header; any priority slot it brings into use is filled first
   task automatic write_header(input logic [7:0] lab, input logic [1:0] rs,
                               input logic dir, input logic [3:0] cnt);
      int len;
      len = cnt > 8 ? 8 : cnt;
      for (int p = 0; p < len; p++)
         if (!prio_written[lab][rs][p]) write_prio(lab, rs, 3'(p), 8'($urandom_range(0, 15)));
      issue(OP_RULE_HDR, lab, rs, dir, cnt, 3'($urandom), 8'($urandom),
            1'($urandom), 1'($urandom));
      hdr_written[lab][rs] = 1'b1;
   endtask

   // Rule count; any rule it brings into use gets a header first
   task automatic write_count(input logic [7:0] lab, input logic [3:0] cnt);
      int nr;
      nr = cnt > 4 ? 4 : cnt;
      for (int r = 0; r < nr; r++)
         if (!hdr_written[lab][r])
            write_header(lab, 2'(r), 1'($urandom), 4'($urandom_range(0, 9)));
      issue(OP_RULE_COUNT, lab, 2'($urandom), 1'($urandom), cnt, 3'($urandom),
            8'($urandom), 1'($urandom), 1'($urandom));
   endtask

   task automatic write_punct(input logic [7:0] lab, input logic flg);
      issue(OP_PUNCT_MARK, lab, 2'($urandom), 1'($urandom), 4'($urandom), 3'($urandom),
            8'($urandom), flg, 1'($urandom));
   endtask

   // A node: children streamed in, the last one carrying the parent label
   task automatic send_node(input logic [7:0] node, input int n, input bit wide_syms);
      logic [7:0] sym;
      for (int i = 0; i < n; i++) begin
         sym = wide_syms ? 8'($urandom) : 8'($urandom_range(0, 15));
         issue(OP_CHILD, (i == n - 1) ? node : 8'($urandom), 2'($urandom), 1'($urandom),
               4'($urandom), 3'($urandom), sym, 1'($urandom), i == n - 1);
      end
   endtask

   // Watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= IDLE_LIMIT) begin
         $display("tb_head_rule_finder: done, errors");
         $finish;
      end
   end

   initial begin
      int kind;
      logic [7:0] lab;
      items_sent = 0;
      quiet = 1'b0;
      bursty = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: saturating counts, both directions, fallbacks, overflow
      write_header(8'd10, 2'd0, 1'b0, 4'd15);
      write_header(8'd10, 2'd3, 1'b1, 4'd8);
      write_prio(8'd10, 2'd3, 3'd7, 8'd255);
      write_count(8'd10, 4'd15);
      write_punct(8'd255, 1'b1);
      write_punct(8'd0, 1'b1);
      send_node(8'd10, 3, 1'b0);
      send_node(8'd200, 2, 1'b0);
      write_header(8'd20, 2'd0, 1'b1, 4'd0);
      write_count(8'd20, 4'd1);
      issue(OP_CHILD, 8'd3, '0, 1'b0, '0, '0, 8'd255, 1'b0, 1'b0);
      issue(OP_CHILD, 8'd20, '0, 1'b0, '0, '0, 8'd0, 1'b0, 1'b1);
      issue(OP_CHILD, 8'd20, '0, 1'b0, '0, '0, 8'd77, 1'b0, 1'b1);
      issue(op_type'(3'd7), 8'hff, 2'd3, 1'b1, 4'hf, 3'd7, 8'hff, 1'b1, 1'b1);
      issue(op_type'(3'd5), 8'h00, 2'd0, 1'b0, 4'h0, 3'd0, 8'h00, 1'b0, 1'b0);
      send_node(8'd10, 18, 1'b1);

      // Random: mostly well-formed nodes over a small label pool
      while (items_sent < 900) begin
         if (items_sent > 780) quiet = 1'b1;
         if ($urandom_range(0, 49) == 0) bursty = !bursty;
         lab = $urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(0, 15));
         kind = $urandom_range(0, 99);
         if (kind < 55)
            send_node(lab, $urandom_range(0, 9) == 0 ? $urandom_range(1, 20)
                                                     : $urandom_range(1, 5),
                      $urandom_range(0, 4) == 0);
         else if (kind < 65) write_count(lab, 4'($urandom));
         else if (kind < 77)
            write_header(lab, 2'($urandom), 1'($urandom), 4'($urandom));
         else if (kind < 87) write_prio(lab, 2'($urandom), 3'($urandom), 8'($urandom));
         else if (kind < 95) write_punct(lab, 1'($urandom));
         else
            issue(op_type'(3'($urandom_range(5, 7))), 8'($urandom), 2'($urandom),
                  1'($urandom), 4'($urandom), 3'($urandom), 8'($urandom),
                  1'($urandom), 1'($urandom));
      end
      start <= 1'b0;

      // Drain, then allow for the longest search
      while (heads_pending != 0) @(posedge clock);
      repeat (700) @(posedge clock);
      $display("Sent %0d request items; checked %0d head results, %0d with overflow.",
               items_sent, heads_checked, overflow_nodes);
      if (fail_count == 0)
         $display("tb_head_rule_finder: done, clean");
      else
         $display("tb_head_rule_finder: done, errors");
      $finish;
   end

endmodule

### sim.f
sv/hrf_pkg.sv
sv/hrf_ram.sv
sv/head_rule_finder.sv
tb/sv/hrf_checker.sv
tb/sv/tb_head_rule_finder.sv
